// ===== design/kiss_deframe_pkg.sv =====
// Shared constants and types for the KISS command deframer.
// Holds the framing byte codes, command codes and result event codes.
// No dependencies.
`default_nettype none

package kiss_deframe_pkg;

  // Default payload limit of a data frame
  localparam int unsigned MAX_FRAME_DEF = 512;

  // Widths of the result fields
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned SVAL_W = 12;

  // Framing bytes
  localparam logic [7:0] KISS_FEND  = 8'hC0;
  localparam logic [7:0] KISS_FESC  = 8'hDB;
  localparam logic [7:0] KISS_TFEND = 8'hDC;
  localparam logic [7:0] KISS_TFESC = 8'hDD;

  // Frame commands after the port nibble is stripped
  typedef enum logic [4:0] {
    CMD_DATAF   = 5'd0,
    CMD_DELAY   = 5'd1,
    CMD_PERSIST = 5'd2,
    CMD_SLOT    = 5'd3,
    CMD_TAIL    = 5'd4,
    CMD_NONE    = 5'd16
  } cmd_t;

  // Result events
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_DATA      = 2'd1,
    EV_FRAME_END = 2'd2,
    EV_SETTING   = 2'd3
  } event_t;

  // Setting identifiers
  typedef enum logic [1:0] {
    SET_TXDELAY = 2'd0,
    SET_PERSIST = 2'd1,
    SET_SLOT    = 2'd2,
    SET_TXTAIL  = 2'd3
  } setting_t;

endpackage

`default_nettype wire

// ===== design/kiss_command_deframer_top.sv =====
// KISS command deframer: decodes one serial byte per beat into one result beat.
// Depends on kiss_deframe_pkg for byte codes, commands and event codes.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------
//   in      | sink      | in_valid, in_ready, in_serial_byte
//   out     | source    | out_valid, out_ready, out_event_res, out_data_byte,
//           |           | out_frame_length, out_setting_id, out_setting_value
//
// Each input beat is decoded in the cycle it is accepted and its result is held
// in the output register, visible on the next cycle.
// A beat is accepted every cycle while the output register is empty or drains
// in the same cycle, so the throughput is one byte per clock.
// Reset (rst_n low, synchronous) clears the frame state and empties the output.
// A stall on out_ready holds the result and stops input acceptance.
`default_nettype none

module kiss_command_deframer_top
  import kiss_deframe_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_serial_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_event_res,
  output logic [7:0]               out_data_byte,
  output logic [LEN_W-1:0]         out_frame_length,
  output logic [1:0]               out_setting_id,
  output logic [SVAL_W-1:0]        out_setting_value
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Frame state
  logic             in_frame_r, in_frame_nxt;
  logic             esc_r, esc_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  // Output register
  logic              out_valid_r;
  event_t            ev_r, ev_nxt;
  logic [7:0]        db_r, db_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  setting_t          sid_r, sid_nxt;
  logic [SVAL_W-1:0] sval_r, sval_nxt;

  logic              in_fire;
  logic [7:0]        ub;
  logic [SVAL_W-1:0] b_ext;
  logic [SVAL_W-1:0] b_x10;
  logic [CNT_W+LEN_W-1:0] len_cur_ext;
  logic [CNT_W+LEN_W-1:0] len_inc_ext;

  // Take a beat while the output register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Count helpers; lengths are reported modulo 2**LEN_W
  assign cnt_inc     = cnt_r + CNT_ONE;
  assign len_cur_ext = {{LEN_W{1'b0}}, cnt_r};
  assign len_inc_ext = {{LEN_W{1'b0}}, cnt_inc};

  // Byte times ten as the sum of two shifted copies
  assign b_ext = {{(SVAL_W-8){1'b0}}, in_serial_byte};
  assign b_x10 = (b_ext << 3) + (b_ext << 1);

  // Undo the escape of a data byte
  always_comb begin
    ub = in_serial_byte;
    if (esc_r) begin
      if (in_serial_byte == KISS_TFEND) begin
        ub = KISS_FEND;
      end else if (in_serial_byte == KISS_TFESC) begin
        ub = KISS_FESC;
      end
    end
  end

  // Decode one byte against the frame state
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    ev_nxt       = EV_NONE;
    db_nxt       = '0;
    len_nxt      = '0;
    sid_nxt      = SET_TXDELAY;
    sval_nxt     = '0;

    if (in_frame_r && in_serial_byte == KISS_FEND && cmd_r == CMD_DATAF) begin
      // close a data frame and report its length
      in_frame_nxt = 1'b0;
      ev_nxt       = EV_FRAME_END;
      len_nxt      = len_cur_ext[LEN_W-1:0];
    end else if (in_serial_byte == KISS_FEND) begin
      // open a new frame; escape flag carries over
      in_frame_nxt = 1'b1;
      cmd_nxt      = CMD_NONE;
      cnt_nxt      = '0;
    end else if (in_frame_r && cnt_r < MAX_CNT) begin
      if (cnt_r == '0 && cmd_r == CMD_NONE) begin
        // strip the port nibble from the command byte
        cmd_nxt = cmd_t'({1'b0, in_serial_byte[3:0]});
      end else begin
        unique case (cmd_r)
          CMD_DATAF: begin
            if (in_serial_byte == KISS_FESC) begin
              esc_nxt = 1'b1;
            end else begin
              esc_nxt = 1'b0;
              cnt_nxt = cnt_inc;
              ev_nxt  = EV_DATA;
              db_nxt  = ub;
              len_nxt = len_inc_ext[LEN_W-1:0];
            end
          end
          CMD_DELAY: begin
            ev_nxt   = EV_SETTING;
            sid_nxt  = SET_TXDELAY;
            sval_nxt = b_x10;
          end
          CMD_PERSIST: begin
            ev_nxt   = EV_SETTING;
            sid_nxt  = SET_PERSIST;
            sval_nxt = b_ext;
          end
          CMD_SLOT: begin
            ev_nxt   = EV_SETTING;
            sid_nxt  = SET_SLOT;
            sval_nxt = b_x10;
          end
          CMD_TAIL: begin
            ev_nxt   = EV_SETTING;
            sid_nxt  = SET_TXTAIL;
            sval_nxt = b_x10;
          end
          default: begin
            // unhandled command: drop the byte
          end
        endcase
      end
    end
  end

  // Advance frame state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      cmd_r      <= CMD_NONE;
      cnt_r      <= '0;
    end else if (in_fire) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      cmd_r      <= cmd_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Output valid: set on accept, clear when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r   <= ev_nxt;
      db_r   <= db_nxt;
      len_r  <= len_nxt;
      sid_r  <= sid_nxt;
      sval_r <= sval_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_data_byte     = db_r;
  assign out_frame_length  = len_r;
  assign out_setting_id    = sid_r;
  assign out_setting_value = sval_r;

  // Payload count never runs past the frame limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("byte count exceeds frame limit");

  // A FEND either closes the frame or restarts the count
  a_fend_effect: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_serial_byte == KISS_FEND |=> !in_frame_r || cnt_r == '0)
    else $error("FEND left frame open with a stale count");

  // Only setting events carry a setting value
  a_sval_only_setting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_r != EV_SETTING |-> sval_r == '0 && sid_r == SET_TXDELAY)
    else $error("setting fields set on a non-setting result");

  // A data frame end never follows a byte that left the frame closed
  a_end_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ev_nxt == EV_FRAME_END |-> in_frame_r && cmd_r == CMD_DATAF)
    else $error("frame end reported outside a data frame");

endmodule

`default_nettype wire
